@@ rtl/apf_pkg.sv @@
// Package for the articulation point finder: payload structs, FSM states,
// controller/datapath command and status structs. No dependencies.
package apf_pkg;
   localparam int unsigned MaxNodesDefault = 64;
   localparam int unsigned MaxResults = 61;

   typedef struct packed {
      logic [5:0] node_a;
      logic [5:0] node_b;
      logic       last_edge;
   } req_type;

   typedef struct packed {
      logic [5:0] cut_node;
      logic [5:0] subnet_count;
      logic       none_found;
      logic       last_result;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_START,
      ST_READ,
      ST_READ_ROW,
      ST_SCAN,
      ST_STEP,
      ST_POP,
      ST_EMIT_RD,
      ST_EMIT,
      ST_NONE,
      ST_CLEAR
   } state_type;

   typedef struct packed {
      logic load_edge;
      logic start;
      logic read_top;
      logic read_row;
      logic scan_step;
      logic act;
      logic pop;
      logic emit_rd;
      logic emit_next;
      logic clear_step;
   } cmd_type;

   typedef struct packed {
      logic scan_done;
      logic found;
      logic stack_empty;
      logic emit_done;
      logic emit_hit;
      logic clear_done;
   } sts_type;
endpackage

@@ rtl/apf_datapath.sv @@
// Datapath: adjacency memory, per-node tables, explicit DFS stack, result scan.
// Depends on apf_pkg.
module apf_datapath #(
   parameter int unsigned MAX_NODES = apf_pkg::MaxNodesDefault
) (
   input  logic             clock,
   input  logic             reset,
   input  apf_pkg::cmd_type cmd,
   input  apf_pkg::req_type req_data,
   output apf_pkg::sts_type sts,
   output logic [5:0]       emit_node,
   output logic [5:0]       emit_count,
   output logic             emit_last_hit
);
   localparam int unsigned NW = $clog2(MAX_NODES);
   localparam int unsigned OW = NW + 1;
   localparam int unsigned DW = NW + 1;

   logic [MAX_NODES-1:0] adj_mem [MAX_NODES];
   logic [OW-1:0]        ord_mem [MAX_NODES];
   logic [OW-1:0]        low_mem [MAX_NODES];
   logic [NW-1:0]        br_mem  [MAX_NODES];
   logic [NW-1:0]        stk_mem [MAX_NODES];
   logic [NW:0]          pos_mem [MAX_NODES];
   logic [MAX_NODES-1:0] vis_ff, cut_ff;

   logic [DW-1:0] depth_ff;
   logic [OW-1:0] cnt_ff;
   logic [NW-1:0] u_ff, par_ff, emit_ff, clr_ff;
   logic          has_par_ff;
   logic [NW:0]   scan_ff;
   logic [MAX_NODES-1:0] row_ff;
   logic [OW-1:0] lowu_ff, ordv_ff, lowp_ff, ordp_ff;
   logic [NW-1:0] br_rd_ff, brp_ff;

   logic a_ok, b_ok;
   logic [NW-1:0] a_idx, b_idx;
   assign a_ok = (req_data.node_a != 6'd0) && ({26'd0, req_data.node_a} < 32'(MAX_NODES));
   assign b_ok = (req_data.node_b != 6'd0) && ({26'd0, req_data.node_b} < 32'(MAX_NODES));
   assign a_idx = NW'(req_data.node_a);
   assign b_idx = NW'(req_data.node_b);

   logic [NW-1:0] top_idx, under_idx;
   assign top_idx = NW'(depth_ff - DW'(1));
   assign under_idx = (depth_ff >= DW'(2)) ? NW'(depth_ff - DW'(2)) : '0;

   // scan: one candidate column per cycle, pausing while a found edge is handled
   logic scan_end, row_bit;
   assign scan_end = (scan_ff >= (NW+1)'(MAX_NODES));
   assign row_bit  = scan_end ? 1'b0 : row_ff[scan_ff[NW-1:0]];
   assign sts.scan_done = scan_end;
   assign sts.found = row_bit;
   assign sts.stack_empty = (depth_ff == '0);
   assign sts.emit_done = (emit_ff == NW'(MAX_NODES-1));
   assign sts.emit_hit = cut_ff[emit_ff] && (emit_ff != '0);
   assign sts.clear_done = (clr_ff == NW'(MAX_NODES-1));

   logic [NW-1:0] v_idx;
   assign v_idx = scan_ff[NW-1:0];

   // later-cut check to mark last result
   logic [MAX_NODES-1:0] above_mask;
   always_comb begin
      for (int i = 0; i < MAX_NODES; i++) begin
         above_mask[i] = (NW'(i) > emit_ff);
      end
   end
   assign emit_last_hit = ((cut_ff & above_mask) == '0);
   assign emit_node = 6'(emit_ff);
   assign emit_count = 6'(br_rd_ff + ((emit_ff != NW'(1)) ? NW'(1) : NW'(0)));

   always_ff @(posedge clock) begin
      br_rd_ff <= br_mem[emit_ff];
      brp_ff <= br_mem[par_ff];
      lowp_ff <= low_mem[par_ff];
      ordp_ff <= ord_mem[par_ff];
      ordv_ff <= ord_mem[v_idx];
      if (cmd.load_edge && a_ok && b_ok) begin
         adj_mem[a_idx][b_idx] <= 1'b1;
         adj_mem[b_idx][a_idx] <= 1'b1;
      end
      if (cmd.clear_step) begin
         adj_mem[clr_ff] <= '0;
         br_mem[clr_ff] <= '0;
      end
      if (cmd.start) begin
         ord_mem[1] <= OW'(1);
         low_mem[1] <= OW'(1);
         pos_mem[1] <= '0;
         stk_mem[0] <= NW'(1);
      end
      if (cmd.read_top) begin
         u_ff <= stk_mem[top_idx];
         par_ff <= stk_mem[under_idx];
         has_par_ff <= (depth_ff >= DW'(2));
      end
      if (cmd.read_row) begin
         scan_ff <= pos_mem[u_ff];
         row_ff <= adj_mem[u_ff];
         lowu_ff <= low_mem[u_ff];
      end else if (cmd.scan_step) begin
         scan_ff <= scan_ff + 1'b1;
      end
      if (cmd.act) begin
         pos_mem[u_ff] <= scan_ff + 1'b1;
         if (!vis_ff[v_idx]) begin
            if (depth_ff < DW'(MAX_NODES)) begin
               ord_mem[v_idx] <= cnt_ff + 1'b1;
               low_mem[v_idx] <= cnt_ff + 1'b1;
               pos_mem[v_idx] <= '0;
               stk_mem[NW'(depth_ff)] <= v_idx;
            end
         end else if (!(has_par_ff && v_idx == par_ff) && ordv_ff < lowu_ff) begin
            low_mem[u_ff] <= ordv_ff;
         end
      end
      if (cmd.pop && has_par_ff) begin
         if (lowu_ff < lowp_ff) low_mem[par_ff] <= lowu_ff;
         if (lowu_ff >= ordp_ff) br_mem[par_ff] <= brp_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vis_ff <= '0; cut_ff <= '0; depth_ff <= '0; cnt_ff <= '0;
         emit_ff <= '0; clr_ff <= '0;
      end else begin
         if (cmd.start) begin
            vis_ff[1] <= 1'b1; depth_ff <= DW'(1); cnt_ff <= OW'(1); emit_ff <= '0;
         end
         if (cmd.act && !vis_ff[v_idx] && depth_ff < DW'(MAX_NODES)) begin
            vis_ff[v_idx] <= 1'b1;
            depth_ff <= depth_ff + 1'b1;
            cnt_ff <= cnt_ff + 1'b1;
         end
         if (cmd.pop) begin
            depth_ff <= depth_ff - 1'b1;
            if (has_par_ff && lowu_ff >= ordp_ff) begin
               if (par_ff != NW'(1) || brp_ff != '0) cut_ff[par_ff] <= 1'b1;
            end
         end
         if (cmd.emit_rd || cmd.emit_next) emit_ff <= emit_ff + 1'b1;
         if (cmd.clear_step) begin
            clr_ff <= sts.clear_done ? '0 : clr_ff + 1'b1;
            vis_ff[clr_ff] <= 1'b0;
            cut_ff[clr_ff] <= 1'b0;
         end
      end
   end
endmodule

@@ rtl/apf_control.sv @@
// Controller FSM: sequences edge load, DFS, result scan and clear.
// Depends on apf_pkg.
module apf_control (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_last,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic             rsp_none,
   input  apf_pkg::sts_type sts,
   output apf_pkg::cmd_type cmd
);
   apf_pkg::state_type state_ff, state_in;
   logic any_ff, any_in;

   always_comb begin
      state_in = state_ff;
      any_in = any_ff;
      unique case (state_ff)
         apf_pkg::ST_LOAD: if (req_valid && req_last) state_in = apf_pkg::ST_START;
         apf_pkg::ST_START: begin
            state_in = apf_pkg::ST_READ;
            any_in = 1'b0;
         end
         apf_pkg::ST_READ: state_in = apf_pkg::ST_READ_ROW;
         apf_pkg::ST_READ_ROW: state_in = apf_pkg::ST_SCAN;
         apf_pkg::ST_SCAN: begin
            if (sts.scan_done) state_in = apf_pkg::ST_POP;
            else if (sts.found) state_in = apf_pkg::ST_STEP;
         end
         apf_pkg::ST_STEP: state_in = apf_pkg::ST_READ;
         apf_pkg::ST_POP: begin
            state_in = sts.stack_empty ? apf_pkg::ST_EMIT_RD : apf_pkg::ST_READ;
         end
         apf_pkg::ST_EMIT_RD: state_in = apf_pkg::ST_EMIT;
         apf_pkg::ST_EMIT: begin
            if (sts.emit_hit) begin
               if (rsp_ready) begin
                  any_in = 1'b1;
                  state_in = sts.emit_done ? apf_pkg::ST_CLEAR : apf_pkg::ST_EMIT_RD;
               end
            end else if (sts.emit_done) begin
               state_in = any_ff ? apf_pkg::ST_CLEAR : apf_pkg::ST_NONE;
            end else begin
               state_in = apf_pkg::ST_EMIT_RD;
            end
         end
         apf_pkg::ST_NONE: if (rsp_ready) state_in = apf_pkg::ST_CLEAR;
         apf_pkg::ST_CLEAR: if (sts.clear_done) state_in = apf_pkg::ST_LOAD;
         default: state_in = apf_pkg::ST_LOAD;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      rsp_none = 1'b0;
      unique case (state_ff)
         apf_pkg::ST_LOAD: begin
            req_ready = 1'b1;
            cmd.load_edge = req_valid;
         end
         apf_pkg::ST_START: cmd.start = 1'b1;
         apf_pkg::ST_READ: cmd.read_top = 1'b1;
         apf_pkg::ST_READ_ROW: cmd.read_row = 1'b1;
         apf_pkg::ST_SCAN: begin
            if (sts.scan_done) cmd.pop = 1'b1;
            else if (!sts.found) cmd.scan_step = 1'b1;
         end
         apf_pkg::ST_STEP: cmd.act = 1'b1;
         apf_pkg::ST_POP: ;
         apf_pkg::ST_EMIT_RD: ;
         apf_pkg::ST_EMIT: begin
            rsp_valid = sts.emit_hit;
            if (!sts.emit_hit && !sts.emit_done) cmd.emit_next = 1'b1;
            if (sts.emit_hit && rsp_ready && !sts.emit_done) cmd.emit_next = 1'b1;
         end
         apf_pkg::ST_NONE: begin
            rsp_valid = 1'b1;
            rsp_none = 1'b1;
         end
         apf_pkg::ST_CLEAR: cmd.clear_step = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= apf_pkg::ST_CLEAR;
         any_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         any_ff <= any_in;
      end
   end
endmodule

@@ rtl/articulation_point_finder.sv @@
// Top level of the articulation point finder.
// Depends on apf_pkg, apf_control, apf_datapath.
//
// Usage: one undirected edge per req_ beat, one beat per cycle while loading.
// The beat with last_edge set starts a depth-first walk from node 1 using an
// explicit stack in on-chip tables; req_ready is low from then until the
// graph is fully reported and cleared. Each walk step reads the stack top and
// then that node's row and tables and scans the row one column per cycle
// until it finds an edge, which it acts on, or reaches the end and pops the
// node. Results go out on rsp_ in ascending node order, one per beat. A graph
// with no cut vertex gives one beat with none_found. last_result marks the
// final beat. A stalled rsp_ready holds the beat and the result scan. After
// the results, a clearing pass wipes the adjacency rows and branch counts;
// the same pass runs after reset, so req_ready stays low until it ends.
module articulation_point_finder #(
   parameter int unsigned MAX_NODES = apf_pkg::MaxNodesDefault
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  apf_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output apf_pkg::rsp_type rsp_data
);
   apf_pkg::cmd_type cmd;
   apf_pkg::sts_type sts;
   logic [5:0] emit_node, emit_count;
   logic emit_last_hit, rsp_none;

   apf_control u_ctl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_last(req_data.last_edge),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_none(rsp_none),
      .sts(sts), .cmd(cmd)
   );

   apf_datapath #(.MAX_NODES(MAX_NODES)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .req_data(req_data), .sts(sts),
      .emit_node(emit_node), .emit_count(emit_count), .emit_last_hit(emit_last_hit)
   );

   always_comb begin
      if (rsp_none) begin
         rsp_data = '{cut_node: 6'd0, subnet_count: 6'd0, none_found: 1'b1,
                      last_result: 1'b1};
      end else begin
         rsp_data = '{cut_node: emit_node, subnet_count: emit_count, none_found: 1'b0,
                      last_result: emit_last_hit};
      end
   end
endmodule

@@ dv/testbench.sv @@
// Testbench for articulation_point_finder: directed and random graphs loaded edge by edge,
// cut vertices predicted by a local depth-first walk and checked per beat.
// Depends on apf_pkg and the articulation_point_finder RTL.
`timescale 1ns / 1ps

module testbench;
   localparam int NodeLimit = 64;
   localparam int WatchdogLimit = 20000;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   apf_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   apf_pkg::rsp_type rsp_data;

   articulation_point_finder dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   apf_pkg::req_type pending_edges[$];
   apf_pkg::rsp_type expected_cuts[$];
   bit      graph_adj[NodeLimit][NodeLimit];
   int      errors;
   int      idle_cycles;
   bit      quiet_mode;
   bit      stimulus_done;
   int      hold_off;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Runs the cut-vertex walk over graph_adj, appends results, clears graph.
   task automatic predict_cuts();
      int order[NodeLimit];
      int lowv[NodeLimit];
      int branches[NodeLimit];
      bit cut[NodeLimit];
      int stk[NodeLimit];
      int scan[NodeLimit];
      int depth, counter, u, par, v, p, n;
      apf_pkg::rsp_type r;
      for (int i = 0; i < NodeLimit; i++) begin
         order[i] = 0; lowv[i] = 0; branches[i] = 0; cut[i] = 0; scan[i] = 0;
      end
      counter = 1; order[1] = 1; lowv[1] = 1; stk[0] = 1; depth = 1;
      while (depth > 0) begin
         u = stk[depth-1];
         par = (depth >= 2) ? stk[depth-2] : NodeLimit;
         v = scan[u];
         while (v < NodeLimit && !graph_adj[u][v]) v++;
         if (v < NodeLimit) begin
            scan[u] = v + 1;
            if (order[v] == 0) begin
               if (depth < NodeLimit) begin
                  counter++;
                  order[v] = counter; lowv[v] = counter; scan[v] = 0;
                  stk[depth] = v; depth++;
               end
            end else if (v != par && order[v] < lowv[u]) begin
               lowv[u] = order[v];
            end
         end else begin
            depth--;
            if (depth > 0) begin
               p = stk[depth-1];
               if (lowv[u] < lowv[p]) lowv[p] = lowv[u];
               if (lowv[u] >= order[p]) begin
                  branches[p]++; cut[p] = 1;
               end
            end
         end
      end
      if (branches[1] < 2) cut[1] = 0;
      n = 0;
      for (int i = 1; i < NodeLimit; i++) begin
         if (cut[i]) begin
            r.cut_node = 6'(i);
            r.subnet_count = 6'(branches[i] + ((i != 1) ? 1 : 0));
            r.none_found = 0; r.last_result = 0;
            expected_cuts.insert(expected_cuts.size(), r);
            n++;
         end
      end
      if (n == 0) begin
         r = '0; r.none_found = 1; r.last_result = 1;
         expected_cuts.insert(expected_cuts.size(), r);
      end else begin
         expected_cuts[expected_cuts.size()-1].last_result = 1;
      end
      for (int i = 0; i < NodeLimit; i++)
         for (int j = 0; j < NodeLimit; j++) graph_adj[i][j] = 0;
   endtask

   function automatic apf_pkg::req_type make_edge(int a, int b, bit last);
      apf_pkg::req_type e;
      e.node_a = 6'(a); e.node_b = 6'(b); e.last_edge = last;
      return e;
   endfunction

   // Graph of n nodes: a chain or tree backbone plus random extra edges.
   task automatic queue_graph(int n, int extra);
      int cnt;
      apf_pkg::req_type g[$];
      for (int i = 2; i <= n; i++)
         g.insert(g.size(), make_edge(i, $urandom_range(1, i - 1), 0));
      for (int k = 0; k < extra; k++) begin
         cnt = $urandom_range(0, 15);
         if (cnt == 0) g.insert(g.size(), make_edge($urandom_range(0, 63), 0, 0));
         else g.insert(g.size(), make_edge($urandom_range(1, n), $urandom_range(1, n), 0));
      end
      g.shuffle();
      if (g.size() == 0) g.insert(0, make_edge(1, 1, 1));
      else g[g.size()-1].last_edge = 1;
      foreach (g[i]) pending_edges.insert(pending_edges.size(), g[i]);
   endtask

   initial begin
      int n, x;
      errors = 0; quiet_mode = 0; stimulus_done = 0;
      // directed
      pending_edges.insert(pending_edges.size(), make_edge(0, 5, 0));
      pending_edges.insert(pending_edges.size(), make_edge(63, 0, 0));
      pending_edges.insert(pending_edges.size(), make_edge(1, 1, 1));
      pending_edges.insert(pending_edges.size(), make_edge(1, 2, 0));
      pending_edges.insert(pending_edges.size(), make_edge(2, 1, 0));
      pending_edges.insert(pending_edges.size(), make_edge(2, 3, 1));
      pending_edges.insert(pending_edges.size(), make_edge(1, 63, 0));
      pending_edges.insert(pending_edges.size(), make_edge(63, 62, 0));
      pending_edges.insert(pending_edges.size(), make_edge(62, 1, 1));
      pending_edges.insert(pending_edges.size(), make_edge(1, 2, 0));
      pending_edges.insert(pending_edges.size(), make_edge(1, 3, 0));
      pending_edges.insert(pending_edges.size(), make_edge(1, 4, 0));
      pending_edges.insert(pending_edges.size(), make_edge(4, 5, 0));
      pending_edges.insert(pending_edges.size(), make_edge(42, 21, 0));
      pending_edges.insert(pending_edges.size(), make_edge(5, 63, 1));
      // long path: many cut vertices
      for (int i = 1; i < 63; i++)
         pending_edges.insert(pending_edges.size(), make_edge(i, i + 1, i == 62));
      while (pending_edges.size() < 95) begin
         n = $urandom_range(1, 12);
         x = $urandom_range(0, n);
         queue_graph(n, x);
      end
      queue_graph(1, 0);
      queue_graph(3, 2);
      queue_graph(4, 2);
   end

   initial begin
      reset = 1;
      repeat (10) @(posedge clock);
      reset <= 0;
   end

   // driver
   int send_gap;
   initial begin
      req_valid = 0; req_data = '0; send_gap = 0;
   end
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            if (req_data.node_a != 0 && req_data.node_b != 0) begin
               graph_adj[req_data.node_a][req_data.node_b] = 1;
               graph_adj[req_data.node_b][req_data.node_a] = 1;
            end
            if (req_data.last_edge) predict_cuts();
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req_valid <= 0;
            end else if (pending_edges.size() > 0) begin
               req_valid <= 1;
               req_data <= pending_edges.pop_front();
               if (!quiet_mode && $urandom_range(0, 5) == 0)
                  send_gap <= $urandom_range(1, 9);
            end else begin
               req_valid <= 0;
               stimulus_done <= 1;
            end
         end
         if (pending_edges.size() < 60) quiet_mode <= 1;
      end
   end

   // monitor
   int stall_gap;
   int beats_seen;
   initial begin
      rsp_ready = 0; stall_gap = 0; beats_seen = 0; hold_off = 0;
   end
   always @(posedge clock) begin
      apf_pkg::rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            beats_seen <= beats_seen + 1;
            if (expected_cuts.size() == 0) begin
               $display("%0t unexpected beat: expected none, actual %p", $time, rsp_data);
               errors++;
            end else begin
               want = expected_cuts.pop_front();
               if (rsp_data !== want) begin
                  $display("%0t mismatch: expected %p, actual %p", $time, want, rsp_data);
                  errors++;
               end
            end
         end
         if (beats_seen == 3 && hold_off == 0) begin
            hold_off <= 400;
            rsp_ready <= 0;
         end else if (hold_off > 1) begin
            hold_off <= hold_off - 1;
            rsp_ready <= 0;
         end else if (stall_gap > 0) begin
            hold_off <= (hold_off == 1) ? -1 : hold_off;
            stall_gap <= stall_gap - 1;
            rsp_ready <= 0;
         end else begin
            hold_off <= (hold_off == 1) ? -1 : hold_off;
            rsp_ready <= 1;
            if (!quiet_mode && $urandom_range(0, 4) == 0)
               stall_gap <= $urandom_range(1, 9);
         end
      end else begin
         rsp_ready <= 0;
      end
   end

   // watchdog and end of run
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      idle_cycles = 0;
      wait (stimulus_done);
      wait (expected_cuts.size() == 0);
      repeat (200) @(posedge clock);
      if (errors == 0 && expected_cuts.size() == 0 && !rsp_valid)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end
endmodule

@@ articulation_point_finder.f @@
rtl/apf_pkg.sv
rtl/apf_datapath.sv
rtl/apf_control.sv
rtl/articulation_point_finder.sv
dv/testbench.sv
